[design/csft_pkg.sv]
package csft_pkg;

    // Default table depth
    localparam int DEF_ENTRIES = 16;

    // Field widths
    localparam int CLIENT_W = 8;
    localparam int ID_W     = 11;
    localparam int IDX_W    = 4;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_MATCH = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOT_FND  = 2'd3;

    typedef enum logic [1:0] {
        OP_SUB   = 2'd0,
        OP_UNS   = 2'd1,
        OP_FLT   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUB,
        ST_UNS,
        ST_FLT
    } state_t;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        RES_NONE,
        RES_SUB_OK,
        RES_FULL,
        RES_PEND_MID,
        RES_PEND_LAST,
        RES_NO_MATCH,
        RES_UNS_OK,
        RES_NOT_FOUND
    } res_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [CLIENT_W-1:0] client;
        logic [ID_W-1:0]     filter_id;
        logic [ID_W-1:0]     filter_mask;
        logic                match_mode;
        logic [ID_W-1:0]     frame_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [CLIENT_W-1:0] dest_client;
        logic [IDX_W-1:0]    entry_index;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [ID_W-1:0]     id;
        logic [ID_W-1:0]     mask;
        logic                mode;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic advance;
        logic mark_found;
        logic shift_wr;
        logic sub_wr;
        logic count_dec;
        logic pend_load;
        res_t emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic full;
        logic chk_vld;
        logic uns_eq;
        logic flt_hit;
        logic scan_done;
        logic found;
        logic pend_vld;
    } ctrl_sts_t;

endpackage

[design/can_subscription_filter_table_core.sv]
// CAN subscription filter table.
// Input channel s_*: one item per request; s_data.opcode selects subscribe,
// unsubscribe, or filter a received frame (opcode 3 is dropped silently).
// Result channel m_*: one item per subscribe or unsubscribe, and one item per
// matching table entry for a frame (or a single no_match); m_data.last marks
// the final item of a request.
// A subscribe loads its item once the output register is free. Unsubscribe
// and frame filtering walk the table through a memory with one read port and
// one write port, one entry per cycle while no filter match waits on the
// output register; an unsubscribe does its compaction inside the same walk.
// s_ready is high only while idle, so a new request is taken only after the
// last one has loaded its final item into the output register.
// A single output register holds the result; the next request is accepted
// while it waits. If the receiver stalls, a filter walk pauses on a match
// that releases a pending match until the output register is taken;
// nothing is dropped. Reset clears the entry count and all control state;
// the memory itself is not cleared, and no clearing pass is needed.
module can_subscription_filter_table_core #(
    parameter int ENTRIES = csft_pkg::DEF_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  csft_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output csft_pkg::out_item_t  m_data
);
    import csft_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    csft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .opcode  (s_data.opcode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    csft_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

[design/csft_ctrl.sv]
module csft_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           opcode,
    output logic                 s_ready,
    input  csft_pkg::ctrl_sts_t  sts,
    output csft_pkg::ctrl_cmd_t  cmd
);
    import csft_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op_t'(opcode))
                        OP_SUB:  state_next = ST_SUB;
                        OP_UNS:  state_next = ST_UNS;
                        OP_FLT:  state_next = ST_FLT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SUB: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_UNS, ST_FLT: begin
                if (sts.scan_done && sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready        = 1'b0;
        cmd.load_req   = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.advance    = 1'b0;
        cmd.mark_found = 1'b0;
        cmd.shift_wr   = 1'b0;
        cmd.sub_wr     = 1'b0;
        cmd.count_dec  = 1'b0;
        cmd.pend_load  = 1'b0;
        cmd.emit       = RES_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_req   = accept;
                cmd.scan_start = accept;
            end
            ST_SUB: begin
                if (sts.out_free) begin
                    if (sts.full) begin
                        cmd.emit = RES_FULL;
                    end else begin
                        cmd.sub_wr = 1'b1;
                        cmd.emit   = RES_SUB_OK;
                    end
                end
            end
            ST_UNS: begin
                if (sts.scan_done) begin
                    if (sts.out_free) begin
                        cmd.count_dec = sts.found;
                        cmd.emit      = sts.found ? RES_UNS_OK : RES_NOT_FOUND;
                    end
                end else begin
                    // once found, every later entry moves down by one
                    cmd.advance = 1'b1;
                    if (sts.chk_vld) begin
                        if (sts.found) begin
                            cmd.shift_wr = 1'b1;
                        end else if (sts.uns_eq) begin
                            cmd.mark_found = 1'b1;
                        end
                    end
                end
            end
            ST_FLT: begin
                if (sts.scan_done) begin
                    if (sts.out_free) begin
                        cmd.emit = sts.pend_vld ? RES_PEND_LAST : RES_NO_MATCH;
                    end
                end else if (!(sts.chk_vld && sts.flt_hit && sts.pend_vld
                               && !sts.out_free)) begin
                    // a hit releases the previous hit, which is then known not last
                    cmd.advance = 1'b1;
                    if (sts.chk_vld && sts.flt_hit) begin
                        cmd.pend_load = 1'b1;
                        if (sts.pend_vld) cmd.emit = RES_PEND_MID;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    a_sub_goes_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && opcode == OP_SUB) |=> state_reg == ST_SUB)
        else $error("accepted subscribe did not enter subscribe state");

    a_flt_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLT && sts.scan_done && sts.out_free)
        |=> state_reg == ST_IDLE)
        else $error("filter scan did not finish after final result");

endmodule

[design/csft_dp.sv]
module csft_dp #(
    parameter int ENTRIES = csft_pkg::DEF_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csft_pkg::in_item_t   s_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output csft_pkg::out_item_t  m_data,
    input  csft_pkg::ctrl_cmd_t  cmd,
    output csft_pkg::ctrl_sts_t  sts
);
    import csft_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    function automatic logic [IDX_W-1:0] out_idx(input logic [AW-1:0] i);
        logic [AW+IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, i};
        return w[IDX_W-1:0];
    endfunction

    // Subscription memory, no reset: entries above the count are never read
    entry_t mem [ENTRIES];

    in_item_t            req_reg;
    entry_t              rd_data_reg;
    logic [AW-1:0]       chk_idx_reg;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                vld_reg, vld_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       hit_idx_reg;
    logic                pend_vld_reg, pend_vld_next;
    logic [CLIENT_W-1:0] pend_client_reg;
    logic [AW-1:0]       pend_idx_reg;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    entry_t              req_entry;
    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    logic                out_free;

    assign req_entry = '{client: req_reg.client, id: req_reg.filter_id,
                         mask: req_reg.filter_mask, mode: req_reg.match_mode};
    assign out_free  = !m_valid_reg || m_ready;
    assign rd_en     = cmd.advance && (ptr_reg < count_reg);

    // Memory write: append or move one entry down
    assign wr_en   = cmd.sub_wr || cmd.shift_wr;
    assign wr_addr = cmd.shift_wr ? (chk_idx_reg - AW'(1)) : count_reg[AW-1:0];
    assign wr_data = cmd.shift_wr ? rd_data_reg : req_entry;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
            chk_idx_reg <= ptr_reg[AW-1:0];
        end
    end

    // Request and pending-hit payload
    always_ff @(posedge aclk) begin
        if (cmd.load_req) req_reg <= s_data;
        if (cmd.mark_found) hit_idx_reg <= chk_idx_reg;
        if (cmd.pend_load) begin
            pend_client_reg <= rd_data_reg.client;
            pend_idx_reg    <= chk_idx_reg;
        end
        m_data_reg <= m_data_next;
    end

    // Scan pointer and flags
    always_comb begin
        ptr_next      = ptr_reg;
        vld_next      = vld_reg;
        found_next    = found_reg;
        pend_vld_next = pend_vld_reg;
        count_next    = count_reg;
        if (cmd.scan_start) begin
            ptr_next      = '0;
            vld_next      = 1'b0;
            found_next    = 1'b0;
            pend_vld_next = 1'b0;
        end else begin
            if (cmd.advance) vld_next = rd_en;
            if (rd_en) ptr_next = ptr_reg + CW'(1);
            if (cmd.mark_found) found_next = 1'b1;
            if (cmd.pend_load) pend_vld_next = 1'b1;
        end
        if (cmd.sub_wr) count_next = count_reg + CW'(1);
        else if (cmd.count_dec) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= '0;
            vld_reg      <= 1'b0;
            found_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            ptr_reg      <= ptr_next;
            vld_reg      <= vld_next;
            found_reg    <= found_next;
            pend_vld_reg <= pend_vld_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Output register
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        if (cmd.emit != RES_NONE) m_valid_next = 1'b1;
        case (cmd.emit)
            RES_SUB_OK:    m_data_next = '{STAT_OK, '0, out_idx(count_reg[AW-1:0]), 1'b1};
            RES_FULL:      m_data_next = '{STAT_FULL, '0, '0, 1'b1};
            RES_PEND_MID:  m_data_next = '{STAT_OK, pend_client_reg,
                                           out_idx(pend_idx_reg), 1'b0};
            RES_PEND_LAST: m_data_next = '{STAT_OK, pend_client_reg,
                                           out_idx(pend_idx_reg), 1'b1};
            RES_NO_MATCH:  m_data_next = '{STAT_NO_MATCH, '0, '0, 1'b1};
            RES_UNS_OK:    m_data_next = '{STAT_OK, '0, out_idx(hit_idx_reg), 1'b1};
            RES_NOT_FOUND: m_data_next = '{STAT_NOT_FND, '0, '0, 1'b1};
            default:       m_data_next = m_data_reg;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status back to the controller
    always_comb begin
        sts.out_free  = out_free;
        sts.full      = (count_reg == CW'(ENTRIES));
        sts.chk_vld   = vld_reg;
        sts.uns_eq    = (rd_data_reg == req_entry);
        sts.flt_hit   = rd_data_reg.mode
                        ? (req_reg.frame_id == rd_data_reg.id)
                        : (((req_reg.frame_id ^ rd_data_reg.id) & rd_data_reg.mask) == '0);
        sts.scan_done = (ptr_reg == count_reg) && !vld_reg;
        sts.found     = found_reg;
        sts.pend_vld  = pend_vld_reg;
    end

    a_shift_after_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_wr |-> (found_reg && !cmd.sub_wr))
        else $error("entry moved before a removal was found");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit != RES_NONE) |-> out_free)
        else $error("result loaded over an untaken result");

    a_pend_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pend_load && pend_vld_reg) |-> (cmd.emit == RES_PEND_MID))
        else $error("pending hit overwritten without being sent");

endmodule
